[hw/rtl/hfma_pkg.sv]
`default_nettype none

package hfma_pkg;

  localparam int DEF_MAX_NODES = 16;
  localparam int PEER_SPAN     = 16;

  localparam int ACTION_W = 2;
  localparam int PEER_W   = 4;
  localparam int KIND_W   = 2;
  localparam int IDX_W    = 4;
  localparam int COUNT_W  = 5;
  localparam int CFG_W    = 5;

  localparam logic [COUNT_W-1:0] RST_NODE_COUNT = 5'd16;

  typedef enum logic [0:0] {
    REG_NODE_INDEX = 1'b0,
    REG_NODE_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_REQ_ENTRY = 2'd0,
    ACT_REPLY_RCV = 2'd1,
    ACT_REQ_RCV   = 2'd2,
    ACT_RELEASE   = 2'd3
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_REQ     = 2'd0,
    KIND_REPLY   = 2'd1,
    KIND_ENTERED = 2'd2,
    KIND_DONE    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CHECK,
    ST_WALK,
    ST_SEND_REPLY,
    ST_SEND_REQ,
    ST_FIN_ENTER,
    ST_FIN_DONE
  } state_t;

  typedef struct packed {
    logic  capture;
    logic  rx_reply;
    logic  rx_req;
    logic  walk_clr;
    logic  walk_adv;
    logic  give_fork;
    logic  drop_token;
    logic  enter_all;
    logic  set_wait;
    logic  emit;
    kind_t kind;
    logic  tgt_walk;
    logic  tgt_peer;
    logic  last;
  } dp_cmd_t;

  typedef struct packed {
    action_t act;
    logic    peer_ok;
    logic    free_now;
    logic    may_enter;
    logic    waiting;
    logic    peer_dirty;
    logic    walk_hit;
    logic    walk_end;
    logic    out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

[hw/rtl/hfma_ctrl.sv]
`default_nettype none

module hfma_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire hfma_pkg::dp_sts_t sts,
  output hfma_pkg::dp_cmd_t     cmd
);

  hfma_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hfma_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.kind  = hfma_pkg::KIND_DONE;
    in_stall  = (state_r != hfma_pkg::ST_IDLE);
    unique case (state_r)
      hfma_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = hfma_pkg::ST_DISPATCH;
        end
      end
      hfma_pkg::ST_DISPATCH: begin
        unique case (sts.act)
          hfma_pkg::ACT_REQ_ENTRY: begin
            state_nxt = sts.free_now ? hfma_pkg::ST_FIN_ENTER : hfma_pkg::ST_WALK;
          end
          hfma_pkg::ACT_REPLY_RCV: begin
            if (sts.peer_ok) begin
              cmd.rx_reply = 1'b1;
              state_nxt    = hfma_pkg::ST_CHECK;
            end else begin
              state_nxt = hfma_pkg::ST_FIN_DONE;
            end
          end
          hfma_pkg::ACT_REQ_RCV: begin
            if (sts.peer_ok) begin
              cmd.rx_req = 1'b1;
              state_nxt  = sts.peer_dirty ? hfma_pkg::ST_SEND_REPLY : hfma_pkg::ST_FIN_DONE;
            end else begin
              state_nxt = hfma_pkg::ST_FIN_DONE;
            end
          end
          default: begin
            state_nxt = hfma_pkg::ST_WALK;
          end
        endcase
      end
      hfma_pkg::ST_CHECK: begin
        if (sts.waiting && sts.may_enter) begin
          cmd.enter_all = 1'b1;
          state_nxt     = hfma_pkg::ST_FIN_ENTER;
        end else begin
          state_nxt = hfma_pkg::ST_FIN_DONE;
        end
      end
      hfma_pkg::ST_WALK: begin
        if (!sts.walk_hit || sts.out_free) begin
          cmd.walk_adv = 1'b1;
          if (sts.walk_hit) begin
            cmd.emit     = 1'b1;
            cmd.walk_clr = 1'b1;
            cmd.tgt_walk = 1'b1;
            cmd.kind     = (sts.act == hfma_pkg::ACT_REQ_ENTRY) ?
                           hfma_pkg::KIND_REQ : hfma_pkg::KIND_REPLY;
          end
          if (sts.walk_end) begin
            state_nxt = hfma_pkg::ST_FIN_DONE;
          end
        end
      end
      hfma_pkg::ST_SEND_REPLY: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.kind      = hfma_pkg::KIND_REPLY;
          cmd.tgt_peer  = 1'b1;
          cmd.give_fork = 1'b1;
          state_nxt     = sts.waiting ? hfma_pkg::ST_SEND_REQ : hfma_pkg::ST_FIN_DONE;
        end
      end
      hfma_pkg::ST_SEND_REQ: begin
        if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.kind       = hfma_pkg::KIND_REQ;
          cmd.tgt_peer   = 1'b1;
          cmd.drop_token = 1'b1;
          state_nxt      = hfma_pkg::ST_FIN_DONE;
        end
      end
      hfma_pkg::ST_FIN_ENTER: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = hfma_pkg::KIND_ENTERED;
          cmd.last  = 1'b1;
          state_nxt = hfma_pkg::ST_IDLE;
        end
      end
      hfma_pkg::ST_FIN_DONE: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.kind     = hfma_pkg::KIND_DONE;
          cmd.last     = 1'b1;
          cmd.set_wait = (sts.act == hfma_pkg::ACT_REQ_ENTRY);
          state_nxt    = hfma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hfma_pkg::ST_IDLE;
      end
    endcase
  end

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("beat emitted into an occupied output register");

  a_last_ends_event: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> (state_r == hfma_pkg::ST_IDLE))
    else $error("final beat did not return controller to idle");

  a_capture_starts_event: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == hfma_pkg::ST_DISPATCH))
    else $error("captured event not dispatched");

  a_set_wait_only_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_wait |-> (sts.act == hfma_pkg::ACT_REQ_ENTRY) && cmd.last)
    else $error("waiting flag set outside request entry");

endmodule

`default_nettype wire

[hw/rtl/hfma_dp.sv]
`default_nettype none

module hfma_dp #(
  parameter int MAX_NODES = hfma_pkg::DEF_MAX_NODES
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [hfma_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire logic [hfma_pkg::ACTION_W-1:0] in_action,
  input  wire logic [hfma_pkg::PEER_W-1:0] in_peer,
  input  wire logic                        out_stall,
  output logic                             out_valid,
  output logic [hfma_pkg::KIND_W-1:0]      out_item_kind,
  output logic [hfma_pkg::PEER_W-1:0]      out_target_peer,
  output logic                             out_last_item,
  input  wire hfma_pkg::dp_cmd_t           cmd,
  output hfma_pkg::dp_sts_t                sts
);

  localparam int PEERS = (MAX_NODES < hfma_pkg::PEER_SPAN) ? MAX_NODES : hfma_pkg::PEER_SPAN;
  localparam int WW    = $clog2(PEERS);
  localparam logic [hfma_pkg::COUNT_W-1:0] PEERS_C = hfma_pkg::COUNT_W'(PEERS);
  localparam logic [WW-1:0] WALK_LAST = WW'(PEERS - 1);

  logic [hfma_pkg::IDX_W-1:0]   node_index_r, node_index_nxt;
  logic [hfma_pkg::COUNT_W-1:0] node_count_r, node_count_nxt;
  logic [PEERS-1:0] held_r, held_nxt;
  logic [PEERS-1:0] dirty_r, dirty_nxt;
  logic [PEERS-1:0] token_r, token_nxt;
  logic             wait_r, wait_nxt;
  hfma_pkg::action_t act_r;
  logic [hfma_pkg::PEER_W-1:0] peer_r;
  logic [WW-1:0]    walk_r, walk_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [hfma_pkg::KIND_W-1:0] kind_r;
  logic [hfma_pkg::PEER_W-1:0] target_r, target_nxt;
  logic             last_r;

  logic             cfg_hit;
  logic [hfma_pkg::IDX_W-1:0] init_idx;
  logic [PEERS-1:0] above_v, below_v, mask_v;
  logic [WW-1:0]    pk;

  assign cfg_hit = cfg_we;
  assign pk      = peer_r[WW-1:0];

  always_comb begin
    if (!rst_n) begin
      init_idx = '0;
    end else if (cfg_we && (cfg_index == hfma_pkg::REG_NODE_INDEX)) begin
      init_idx = cfg_wdata[hfma_pkg::IDX_W-1:0];
    end else begin
      init_idx = node_index_r;
    end
  end

  always_comb begin
    for (int p = 0; p < PEERS; p++) begin
      above_v[p] = hfma_pkg::COUNT_W'(p) > {1'b0, init_idx};
      below_v[p] = hfma_pkg::COUNT_W'(p) < {1'b0, init_idx};
      mask_v[p]  = (hfma_pkg::COUNT_W'(p) < node_count_r) &&
                   (hfma_pkg::COUNT_W'(p) != {1'b0, node_index_r});
    end
  end

  always_comb begin
    sts.act        = act_r;
    sts.peer_ok    = ({1'b0, peer_r} < PEERS_C) && mask_v[pk];
    sts.free_now   = &(~mask_v | (held_r & ~token_r));
    sts.may_enter  = &(~mask_v | (held_r & ~(dirty_r & token_r)));
    sts.waiting    = wait_r;
    sts.peer_dirty = dirty_r[pk];
    sts.walk_hit   = mask_v[walk_r] & token_r[walk_r];
    sts.walk_end   = (walk_r == WALK_LAST);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  always_comb begin
    node_index_nxt = node_index_r;
    node_count_nxt = node_count_r;
    held_nxt       = held_r;
    dirty_nxt      = dirty_r;
    token_nxt      = token_r;
    wait_nxt       = wait_r;
    if (cfg_hit) begin
      if (cfg_index == hfma_pkg::REG_NODE_INDEX) begin
        node_index_nxt = cfg_wdata[hfma_pkg::IDX_W-1:0];
      end else begin
        node_count_nxt = cfg_wdata[hfma_pkg::COUNT_W-1:0];
      end
      held_nxt  = above_v;
      dirty_nxt = above_v;
      token_nxt = below_v;
      wait_nxt  = 1'b0;
    end else begin
      if (cmd.rx_reply) begin
        held_nxt[pk]  = 1'b1;
        dirty_nxt[pk] = 1'b0;
      end
      if (cmd.rx_req) begin
        token_nxt[pk] = 1'b1;
      end
      if (cmd.give_fork) begin
        held_nxt[pk]  = 1'b0;
        dirty_nxt[pk] = 1'b0;
      end
      if (cmd.drop_token) begin
        token_nxt[pk] = 1'b0;
      end
      if (cmd.walk_clr) begin
        if (act_r == hfma_pkg::ACT_REQ_ENTRY) begin
          token_nxt[walk_r] = 1'b0;
        end else begin
          held_nxt[walk_r]  = 1'b0;
          dirty_nxt[walk_r] = 1'b0;
        end
      end
      if (cmd.enter_all) begin
        dirty_nxt = dirty_r | mask_v;
        wait_nxt  = 1'b0;
      end
      if (cmd.set_wait) begin
        wait_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    walk_nxt = walk_r;
    if (cmd.capture) begin
      walk_nxt = '0;
    end else if (cmd.walk_adv) begin
      walk_nxt = walk_r + WW'(1);
    end
  end

  always_comb begin
    if (cmd.tgt_walk) begin
      target_nxt = hfma_pkg::PEER_W'(walk_r);
    end else if (cmd.tgt_peer) begin
      target_nxt = peer_r;
    end else begin
      target_nxt = '0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_index_r <= '0;
      node_count_r <= hfma_pkg::RST_NODE_COUNT;
      held_r       <= above_v;
      dirty_r      <= above_v;
      token_r      <= below_v;
      wait_r       <= 1'b0;
      walk_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      node_index_r <= node_index_nxt;
      node_count_r <= node_count_nxt;
      held_r       <= held_nxt;
      dirty_r      <= dirty_nxt;
      token_r      <= token_nxt;
      wait_r       <= wait_nxt;
      walk_r       <= walk_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= hfma_pkg::action_t'(in_action);
      peer_r <= in_peer;
    end
    if (cmd.emit) begin
      kind_r   <= cmd.kind;
      target_r <= target_nxt;
      last_r   <= cmd.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_item_kind   = kind_r;
  assign out_target_peer = target_r;
  assign out_last_item   = last_r;

  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |->
      (kind_r == hfma_pkg::KIND_ENTERED) || (kind_r == hfma_pkg::KIND_DONE))
    else $error("final beat carries a message kind");

  a_msg_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !last_r) |->
      (kind_r == hfma_pkg::KIND_REQ) || (kind_r == hfma_pkg::KIND_REPLY))
    else $error("status beat not marked final");

  a_status_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> (target_r == '0))
    else $error("status beat with nonzero target");

endmodule

`default_nettype wire

[hw/rtl/hygienic_fork_mutex_agent_unit.sv]
// An accepted event passes dispatch (a reply also check) before its first beat is registered.
// Release, and request entry unless the node may enter at once, walk all min(MAX_NODES,16)
// peer slots, one per cycle unless an output stall holds a slot that has a beat to send.
// One event is in flight at a time; the next is accepted once its final beat is registered.
// Synchronous active-low reset: node_index 0, node_count 16, peer bits from index 0,
// not waiting, output empty.
`default_nettype none

module hygienic_fork_mutex_agent_unit #(
  parameter int MAX_NODES = hfma_pkg::DEF_MAX_NODES
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [hfma_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [hfma_pkg::ACTION_W-1:0] in_action,
  input  wire logic [hfma_pkg::PEER_W-1:0]   in_peer,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [hfma_pkg::KIND_W-1:0]        out_item_kind,
  output logic [hfma_pkg::PEER_W-1:0]        out_target_peer,
  output logic                               out_last_item
);

  hfma_pkg::dp_cmd_t cmd;
  hfma_pkg::dp_sts_t sts;

  hfma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hfma_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_action       (in_action),
    .in_peer         (in_peer),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_item_kind   (out_item_kind),
    .out_target_peer (out_target_peer),
    .out_last_item   (out_last_item),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

`default_nettype wire
